// ----- src/fpc_pkg.sv -----
// Package for the float precision converter: command codes and conversion functions.
// Used by fpc_core and float_precision_converter; depends on nothing.
package fpc_pkg;

  typedef enum logic [1:0] {
    CMD_F32_TO_F16  = 2'd0,
    CMD_F16_TO_F32  = 2'd1,
    CMD_F32_TO_BF16 = 2'd2,
    CMD_BF16_TO_F32 = 2'd3
  } cmd_t;

  function automatic logic [15:0] narrow_half(input logic [31:0] x);
    logic        sgn;
    logic [7:0]  ex;
    logic [22:0] man;
    logic [23:0] m;
    logic [4:0]  s;
    logic [23:0] q;
    logic [23:0] rem;
    logic [23:0] half;
    logic [14:0] h;
    logic [12:0] r13;
    logic [15:0] res;
    sgn = x[31];
    ex  = x[30:23];
    man = x[22:0];
    m   = {1'b1, man};
    s   = 5'(8'd126 - ex);
    q   = m >> s;
    rem = m & ((24'd1 << s) - 24'd1);
    half = 24'd1 << (s - 5'd1);
    h   = {5'(ex - 8'd112), man[22:13]};
    r13 = man[12:0];
    if (ex == 8'hFF) begin
      if (man == 23'd0) res = {sgn, 15'h7C00};
      else res = {sgn, 5'h1F, man[22:13] | 10'd1};
    end else if (ex < 8'd103) begin
      res = {sgn, 15'd0};
    end else if (ex <= 8'd112) begin
      if (rem > half || (rem == half && q[0])) q = q + 24'd1;
      res = {sgn, q[14:0]};
    end else if (ex >= 8'd143) begin
      res = {sgn, 15'h7C00};
    end else begin
      if (r13 > 13'h1000 || (r13 == 13'h1000 && h[0])) h = h + 15'd1;
      res = {sgn, h};
    end
    return res;
  endfunction

  function automatic logic [31:0] widen_half(input logic [15:0] h);
    logic       sgn;
    logic [4:0] ex;
    logic [9:0] man;
    logic [3:0] p;
    logic [9:0] sh;
    logic [31:0] res;
    sgn = h[15];
    ex  = h[14:10];
    man = h[9:0];
    p   = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (man[i]) p = 4'(i);
    end
    sh = man << (4'd10 - p);
    if (ex == 5'd0) begin
      if (man == 10'd0) res = {sgn, 31'd0};
      else res = {sgn, 8'(8'd103 + {4'd0, p}), sh, 13'd0};
    end else if (ex == 5'h1F) begin
      if (man == 10'd0) res = {sgn, 31'h7F800000};
      else res = {sgn, 8'hFF, 1'b1, man[8:0], 13'd0};
    end else begin
      res = {sgn, 8'(8'd112 + {3'd0, ex}), man, 13'd0};
    end
    return res;
  endfunction

  function automatic logic [15:0] narrow_bf16(input logic [31:0] x);
    logic [32:0] sum;
    logic [15:0] res;
    sum = {1'b0, x} + 33'h7FFF + {32'd0, x[16]};
    if (x[30:23] == 8'hFF && x[22:0] != 23'd0) res = x[31:16] | 16'h0040;
    else res = sum[31:16];
    return res;
  endfunction

endpackage

// ----- src/float_precision_converter.sv -----
// Top level of the float precision converter: input register, datapath, result register.
// Depends on fpc_pkg and fpc_core.
//
//   channel  ports                          handshake
//   input    in_command, in_operand         start & !busy
//   result   out_converted                  out_valid, one cycle
//
// An item is registered at its accepting edge and converted during the next cycle.
// Its result is registered at the following edge, where out_valid rises.
// One item is taken every cycle; busy is always low and the receiver cannot stall.
// Reset clears the valid flags only.
module float_precision_converter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_operand,
  output logic        out_valid,
  output logic [31:0] out_converted
);

  logic        in_vld_r;
  logic [1:0]  cmd_r;
  logic [31:0] op_r;
  logic [31:0] conv_nxt;
  logic        out_vld_r;
  logic [31:0] res_r;

  assign busy = 1'b0;

  fpc_core u_core (
    .cmd       (cmd_r),
    .operand   (op_r),
    .converted (conv_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= start;
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cmd_r <= in_command;
      op_r  <= in_operand;
    end
    if (in_vld_r) res_r <= conv_nxt;
  end

  assign out_valid     = out_vld_r;
  assign out_converted = res_r;

`ifndef ASSERT_OFF
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> ##1 out_valid) else $error("result not delivered");
  a_noinv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_vld_r)) else $error("spurious result");
  a_hi: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && (cmd_r == fpc_pkg::CMD_F32_TO_F16 || cmd_r == fpc_pkg::CMD_F32_TO_BF16))
    |=> out_converted[31:16] == 16'd0) else $error("upper bits set on narrow");
`endif

endmodule

// ----- src/fpc_core.sv -----
// Combinational conversion datapath for the float precision converter.
// Depends on fpc_pkg for command codes and per-format functions.
module fpc_core (
  input  logic [1:0]  cmd,
  input  logic [31:0] operand,
  output logic [31:0] converted
);

  always_comb begin
    case (fpc_pkg::cmd_t'(cmd))
      fpc_pkg::CMD_F32_TO_F16:  converted = {16'd0, fpc_pkg::narrow_half(operand)};
      fpc_pkg::CMD_F16_TO_F32:  converted = fpc_pkg::widen_half(operand[15:0]);
      fpc_pkg::CMD_F32_TO_BF16: converted = {16'd0, fpc_pkg::narrow_bf16(operand)};
      fpc_pkg::CMD_BF16_TO_F32: converted = {operand[15:0], 16'd0};
      default:                  converted = 32'd0;
    endcase
  end

endmodule
